>>> sv/dat_pkg.sv
// Package for the dome azimuth tracker: operation, direction and shutter codes,
// payload structs and the stage struct shared by the pipeline modules.
// No dependencies.
`default_nettype none

package dat_pkg;

	localparam int unsigned AngleW = 32;
	localparam int unsigned MsW    = 16;

	typedef logic [AngleW-1:0] angle_t;

	typedef enum logic [3:0] {
		OP_TICK      = 4'd0,
		OP_SEEK_ABS  = 4'd1,
		OP_SEEK_REL  = 4'd2,
		OP_TURN_CW   = 4'd3,
		OP_TURN_CCW  = 4'd4,
		OP_STOP      = 4'd5,
		OP_OPEN      = 4'd6,
		OP_CLOSE     = 4'd7,
		OP_ABORT     = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_CW   = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		SH_STOPPED = 3'd0,
		SH_OPENING = 3'd1,
		SH_OPEN    = 3'd2,
		SH_CLOSING = 3'd3,
		SH_CLOSED  = 3'd4
	} shut_t;

	typedef enum logic [1:0] {
		DRV_STOP  = 2'd0,
		DRV_OPEN  = 2'd1,
		DRV_CLOSE = 2'd2
	} sdrive_t;

	typedef enum logic [1:0] {
		REG_SPEED_CW      = 2'd0,
		REG_SPEED_CCW     = 2'd1,
		REG_IMPULSE_PITCH = 2'd2,
		REG_NORTH_OFFSET  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [3:0]     operation;
		logic [MsW-1:0] elapsed_ms;
		logic           north_seen;
		logic           impulse_level;
		logic           open_limit;
		logic           closed_limit;
		angle_t         angle_arg;
	} cmd_t;

	typedef struct packed {
		logic [1:0] motor_drive;
		logic [1:0] shutter_drive;
		angle_t     azimuth;
		logic [2:0] shutter_status;
		logic       seek_active;
		logic       target_reached;
		logic       command_busy;
	} res_t;

	typedef struct packed {
		angle_t speed_cw;
		angle_t speed_ccw;
		angle_t impulse_pitch;
		angle_t north_offset;
	} cfg_t;

	// event plus both dead-reckoning steps, handed from the multiply stage
	typedef struct packed {
		logic   valid;
		cmd_t   cmd;
		angle_t delta_cw;
		angle_t delta_ccw;
	} stage_t;

endpackage

`default_nettype wire

>>> sv/dat_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Used for the event and result channels of the dome azimuth tracker.
`default_nettype none

interface dat_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/dat_delta.sv
// Multiply stage: turns elapsed milliseconds into angle steps for both
// directions. Depends on dat_pkg.
`default_nettype none

module dat_delta
	import dat_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   valid_s1,
	input  wire cmd_t   cmd_s1,
	input  wire cfg_t   cfg,
	output stage_t      stage_s2
);

	logic [AngleW+MsW-1:0] prod_cw;
	logic [AngleW+MsW-1:0] prod_ccw;
	logic                  valid_s2;
	cmd_t                  cmd_s2;
	angle_t                delta_cw_s2;
	angle_t                delta_ccw_s2;

	// only the low word matters: angles wrap at a full turn
	assign prod_cw  = cfg.speed_cw * cmd_s1.elapsed_ms;
	assign prod_ccw = cfg.speed_ccw * cmd_s1.elapsed_ms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2       <= cmd_s1;
			delta_cw_s2  <= prod_cw[AngleW-1:0];
			delta_ccw_s2 <= prod_ccw[AngleW-1:0];
		end
	end

	always_comb begin
		stage_s2.valid     = valid_s2;
		stage_s2.cmd       = cmd_s2;
		stage_s2.delta_cw  = delta_cw_s2;
		stage_s2.delta_ccw = delta_ccw_s2;
	end

endmodule

`default_nettype wire

>>> sv/dat_ctrl.sv
// Tracker state and result register: dead reckoning, impulse and north
// correction, seek steering, shutter sequencing and commands. Depends on dat_pkg.
`default_nettype none

module dat_ctrl
	import dat_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire stage_t stage_s2,
	input  wire cfg_t   cfg,
	output logic        res_valid,
	output res_t        res_data
);

	angle_t pos_q, cw_imp_q, ccw_imp_q, target_q;
	logic   last_imp_q, seeking_q;
	dir_t   dir_q;
	shut_t  shut_q;

	angle_t pos_n, cw_imp_n, ccw_imp_n, target_n, nxt;
	logic   last_imp_n, seeking_n, reached, busy, rising, falling;
	dir_t   dir_n;
	shut_t  shut_n, status;
	logic   res_valid_q;
	res_t   res_s3, res_n;
	logic   step;
	cmd_t   c;

	function automatic logic front_half(input angle_t a, input angle_t t);
		angle_t d;
		d = a - t;
		return ~d[AngleW-1];
	endfunction

	assign step = en && stage_s2.valid;
	assign c    = stage_s2.cmd;

	always_comb begin
		pos_n      = pos_q;
		cw_imp_n   = cw_imp_q;
		ccw_imp_n  = ccw_imp_q;
		target_n   = target_q;
		last_imp_n = last_imp_q;
		seeking_n  = seeking_q;
		dir_n      = dir_q;
		shut_n     = shut_q;
		reached    = 1'b0;
		busy       = 1'b0;
		nxt        = pos_q;
		rising     = c.impulse_level && !last_imp_q;
		falling    = !c.impulse_level && last_imp_q;

		case (op_t'(c.operation))
			OP_TICK: begin
				if (shut_q == SH_OPENING && c.open_limit)
					shut_n = SH_OPEN;
				else if (shut_q == SH_CLOSING && c.closed_limit)
					shut_n = SH_CLOSED;

				if (dir_q == DIR_CW) begin
					nxt = pos_q + stage_s2.delta_cw;
					if (rising) begin
						nxt       = cw_imp_q;
						cw_imp_n  = cw_imp_q + cfg.impulse_pitch;
						ccw_imp_n = cw_imp_q - cfg.impulse_pitch;
					end
					if (falling)
						ccw_imp_n = ccw_imp_q + cfg.impulse_pitch;
				end else if (dir_q == DIR_CCW) begin
					nxt = pos_q - stage_s2.delta_ccw;
					if (rising) begin
						nxt       = ccw_imp_q;
						ccw_imp_n = ccw_imp_q - cfg.impulse_pitch;
						cw_imp_n  = ccw_imp_q + cfg.impulse_pitch;
					end
					if (falling)
						cw_imp_n = cw_imp_q - cfg.impulse_pitch;
				end

				// north resets the angle; a zero offset puts an impulse at north
				if (c.north_seen) begin
					nxt       = '0;
					cw_imp_n  = (cfg.north_offset == '0) ? cfg.impulse_pitch
						: cfg.north_offset;
					ccw_imp_n = cfg.north_offset - cfg.impulse_pitch;
				end
				last_imp_n = c.impulse_level;

				// stop on a change of half: target or its antipode crossed
				if (seeking_q && (front_half(pos_q, target_q) != front_half(nxt, target_q)))
				begin
					seeking_n = 1'b0;
					dir_n     = DIR_NONE;
					reached   = 1'b1;
				end
				pos_n = nxt;
				if (seeking_n)
					dir_n = front_half(nxt, target_q) ? DIR_CCW : DIR_CW;
			end
			OP_SEEK_ABS: begin
				target_n  = c.angle_arg;
				seeking_n = 1'b1;
				busy      = 1'b1;
			end
			OP_SEEK_REL: begin
				target_n  = pos_q + c.angle_arg;
				seeking_n = 1'b1;
				busy      = 1'b1;
			end
			OP_TURN_CW: begin
				seeking_n = 1'b0;
				dir_n     = DIR_CW;
				busy      = 1'b1;
			end
			OP_TURN_CCW: begin
				seeking_n = 1'b0;
				dir_n     = DIR_CCW;
				busy      = 1'b1;
			end
			OP_STOP: begin
				seeking_n = 1'b0;
				dir_n     = DIR_NONE;
			end
			OP_OPEN: begin
				if (shut_q != SH_OPEN) begin
					shut_n = SH_OPENING;
					busy   = 1'b1;
				end
			end
			OP_CLOSE: begin
				if (shut_q != SH_CLOSED) begin
					shut_n = SH_CLOSING;
					busy   = 1'b1;
				end
			end
			OP_ABORT: begin
				if (shut_q == SH_OPENING || shut_q == SH_CLOSING)
					shut_n = SH_STOPPED;
				seeking_n = 1'b0;
				dir_n     = DIR_NONE;
			end
			default: begin
			end
		endcase

		case (shut_n)
			SH_OPENING, SH_OPEN, SH_CLOSING, SH_CLOSED: status = shut_n;
			default:                                    status = SH_STOPPED;
		endcase

		res_n.motor_drive    = dir_n;
		res_n.shutter_drive  = (status == SH_OPENING) ? DRV_OPEN
			: (status == SH_CLOSING) ? DRV_CLOSE : DRV_STOP;
		res_n.azimuth        = pos_n;
		res_n.shutter_status = status;
		res_n.seek_active    = seeking_n;
		res_n.target_reached = reached;
		res_n.command_busy   = busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			cw_imp_q    <= '0;
			ccw_imp_q   <= '0;
			target_q    <= '0;
			last_imp_q  <= 1'b0;
			seeking_q   <= 1'b0;
			dir_q       <= DIR_NONE;
			shut_q      <= SH_STOPPED;
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				pos_q      <= pos_n;
				cw_imp_q   <= cw_imp_n;
				ccw_imp_q  <= ccw_imp_n;
				target_q   <= target_n;
				last_imp_q <= last_imp_n;
				seeking_q  <= seeking_n;
				dir_q      <= dir_n;
				shut_q     <= shut_n;
			end
			if (en)
				res_valid_q <= stage_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_s3 <= res_n;
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_s3;

	// north on a tick leaves the azimuth at zero
	a_north_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(step && op_t'(c.operation) == OP_TICK && c.north_seen) |=> pos_q == '0)
		else $error("azimuth not zeroed at north");

	// a shutter reaches open only from opening
	a_open_from_opening: assert property (@(posedge clk) disable iff (!arst_n)
		(shut_q == SH_OPEN && $past(shut_q) != SH_OPEN) |-> $past(shut_q) == SH_OPENING)
		else $error("shutter opened without opening");

	// a result that reports the target reached has stopped rotation and seek
	a_reached_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_s3.target_reached) |->
		(!res_s3.seek_active && res_s3.motor_drive == DIR_NONE && !res_s3.command_busy))
		else $error("target reached but still driving");

	// state moves only when an event leaves the multiply stage
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(step) |-> ($stable(pos_q) && $stable(seeking_q) && $stable(shut_q)))
		else $error("tracker state changed without an event");

endmodule

`default_nettype wire

>>> sv/dome_azimuth_tracker.sv
// Dome azimuth tracker: event-driven dome rotation and shutter controller.
// Pipeline: an accepted event passes the input register, the multiply stage and the result register in order.
// Throughput: one event per cycle; the whole pipe holds while a result waits.
// Reset: arst_n clears tracker state, configuration registers and valid flags.
// Depends on dat_pkg, dat_stream_if, dat_delta and dat_ctrl.
`default_nettype none

module dome_azimuth_tracker
	import dat_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	dat_stream_if.sink        cmd,
	dat_stream_if.source      res,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_wdata
);

	cfg_t   cfg_q;
	logic   en;
	logic   valid_s1;
	cmd_t   cmd_s1;
	stage_t stage_s2;
	logic   res_valid;
	res_t   res_data;

	// advance the whole pipe unless the result register is held
	assign en        = !res_valid || res.ready;
	assign cmd.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SPEED_CW:      cfg_q.speed_cw      <= cfg_wdata;
				REG_SPEED_CCW:     cfg_q.speed_ccw     <= cfg_wdata;
				REG_IMPULSE_PITCH: cfg_q.impulse_pitch <= cfg_wdata;
				REG_NORTH_OFFSET:  cfg_q.north_offset  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			cmd_s1 <= cmd.data;
	end

	dat_delta u_delta (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.cmd_s1   (cmd_s1),
		.cfg      (cfg_q),
		.stage_s2 (stage_s2)
	);

	dat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.stage_s2  (stage_s2),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	assign res.valid = res_valid;
	assign res.data  = res_data;

endmodule

`default_nettype wire
